[src/binary_image_coast_pixel_counter_assert.svh]
// Assertion macros for the coast pixel counter.
// Used by the top level only; no other dependencies.
`ifndef BINARY_IMAGE_COAST_PIXEL_COUNTER_ASSERT_SVH
`define BINARY_IMAGE_COAST_PIXEL_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCPC_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCPC_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[src/bcpc_pkg.sv]
// Shared types and constants for the coast pixel counter.
// No dependencies; used by every module of the block.
package bcpc_pkg;

    localparam int MaxColsDefault = 1024;
    localparam int MaxRowsDefault = 1024;
    localparam int CfgW           = 11;
    localparam int CfgIdxW        = 2;
    localparam int CountW         = 21;
    localparam int InTdataW       = 8;
    localparam int OutTdataW      = 24;

    typedef enum logic [CfgIdxW-1:0] {
        REG_IMAGE_ROWS = 2'd0,
        REG_IMAGE_COLS = 2'd1
    } bcpc_reg_t;

    // One line store entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        logic above;
        logic up;
    } bcpc_word_t;

endpackage

[src/bcpc_line_store.sv]
// Line store for the coast pixel counter: one write port, one registered read port.
// Depends on bcpc_pkg for the entry type.
module bcpc_line_store #(
    parameter int DEPTH = bcpc_pkg::MaxColsDefault,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  bcpc_pkg::bcpc_word_t wr_word,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output bcpc_pkg::bcpc_word_t rd_word
);

    bcpc_pkg::bcpc_word_t mem [DEPTH];
    bcpc_pkg::bcpc_word_t rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

[src/bcpc_result_buf.sv]
// Two-entry result buffer that decouples the pixel side from the result side.
// Depends on bcpc_pkg for the count width.
module bcpc_result_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [bcpc_pkg::CountW-1:0] push_count,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bcpc_pkg::CountW-1:0] out_count
);

    logic                        head_valid_reg;
    logic                        skid_valid_reg;
    logic [bcpc_pkg::CountW-1:0] head_count_reg;
    logic [bcpc_pkg::CountW-1:0] skid_count_reg;
    logic                        pop;

    assign pop       = head_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_count = head_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (head_valid_reg)
        begin
            if (push && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (!push && pop)
            begin
                head_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            head_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_count_reg <= skid_count_reg;
            end
        end
        else if (push)
        begin
            if (head_valid_reg && !pop)
            begin
                skid_count_reg <= push_count;
            end
            else
            begin
                head_count_reg <= push_count;
            end
        end
    end

endmodule

[src/binary_image_coast_pixel_counter.sv]
// Top level of the coast pixel counter: raster pixel input, frame count output.
// Depends on bcpc_pkg, bcpc_line_store, bcpc_result_buf and the assertion header.
//
//   Channel   Dir  Handshake            Payload
//   s_*       in   s_tvalid/s_tready    s_tdata[0] is_land
//   m_*       out  m_tvalid/m_tready    m_tdata[20:0] coast_count
//   cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (image_rows, image_cols)
//
// One pixel is accepted per cycle while s_tready is high; the line store read for the next
// column is issued with each request, so its registered port has the entry in time.
// The count appears on m_tdata at the earliest in the cycle after the frame's last pixel
// is accepted, later when an older count still waits on the result side.
// Reset clears the position, the count and the result buffer; the line store is not
// cleared. s_tready drops only while two counts wait on the result side.
`include "binary_image_coast_pixel_counter_assert.svh"

module binary_image_coast_pixel_counter #(
    parameter int MAX_COLS = bcpc_pkg::MaxColsDefault,
    parameter int MAX_ROWS = bcpc_pkg::MaxRowsDefault
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bcpc_pkg::InTdataW-1:0]  s_tdata,   // [0] is_land
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bcpc_pkg::OutTdataW-1:0] m_tdata,   // [20:0] coast_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bcpc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [bcpc_pkg::CfgW-1:0]      cfg_data
);

    localparam int ColW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RowW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ColCmpW = (ColW + 1 > bcpc_pkg::CfgW) ? ColW + 1 : bcpc_pkg::CfgW;
    localparam int RowCmpW = (RowW + 1 > bcpc_pkg::CfgW) ? RowW + 1 : bcpc_pkg::CfgW;

    logic [bcpc_pkg::CfgW-1:0]   image_rows_reg;
    logic [bcpc_pkg::CfgW-1:0]   image_cols_reg;
    logic [RowW-1:0]             row_index_reg;
    logic [RowW-1:0]             row_index_next;
    logic [ColW-1:0]             col_index_reg;
    logic [ColW-1:0]             col_index_next;
    logic [bcpc_pkg::CountW-1:0] running_count_reg;
    logic [bcpc_pkg::CountW-1:0] count_sum;
    logic                        pend_valid_reg;
    logic                        pend_forced_reg;
    logic                        pend_forced_next;
    logic                        left_up_reg;
    logic                        rd_bypass_reg;
    bcpc_pkg::bcpc_word_t        bypass_word_reg;
    bcpc_pkg::bcpc_word_t        mem_rd_word;
    bcpc_pkg::bcpc_word_t        cur_word;
    bcpc_pkg::bcpc_word_t        wr_word;

    logic [RowCmpW-1:0]          rows_eff;
    logic [ColCmpW-1:0]          cols_eff;
    logic [RowCmpW-1:0]          row_plus;
    logic [ColCmpW-1:0]          col_plus;
    logic                        last_row;
    logic                        last_col;
    logic                        frame_done;
    logic                        pix;
    logic                        in_accept;
    logic                        inc_pend;
    logic                        inc_upper;
    logic                        inc_last;
    logic                        upper_active;
    logic                        upper_border;
    logic                        set_pend;
    logic                        buf_in_ready;
    logic [bcpc_pkg::CountW-1:0] out_count;

    assign cfg_ready = 1'b1;
    assign s_tready  = buf_in_ready;
    assign in_accept = s_tvalid && s_tready;
    assign pix       = s_tdata[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg <= bcpc_pkg::CfgW'(1);
            image_cols_reg <= bcpc_pkg::CfgW'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bcpc_pkg::REG_IMAGE_ROWS: image_rows_reg <= cfg_data;
                bcpc_pkg::REG_IMAGE_COLS: image_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rows_eff = RowCmpW'(image_rows_reg);
        if (image_rows_reg == '0)
        begin
            rows_eff = RowCmpW'(1);
        end
        else if (rows_eff > RowCmpW'(MAX_ROWS))
        begin
            rows_eff = RowCmpW'(MAX_ROWS);
        end

        cols_eff = ColCmpW'(image_cols_reg);
        if (image_cols_reg == '0)
        begin
            cols_eff = ColCmpW'(1);
        end
        else if (cols_eff > ColCmpW'(MAX_COLS))
        begin
            cols_eff = ColCmpW'(MAX_COLS);
        end

        row_plus   = RowCmpW'(row_index_reg) + RowCmpW'(1);
        col_plus   = ColCmpW'(col_index_reg) + ColCmpW'(1);
        last_row   = row_plus >= rows_eff;
        last_col   = col_plus >= cols_eff;
        frame_done = last_row && last_col;

        col_index_next = last_col ? '0 : col_plus[ColW-1:0];
        row_index_next = row_index_reg;
        if (last_col)
        begin
            row_index_next = last_row ? '0 : row_plus[RowW-1:0];
        end

        cur_word = rd_bypass_reg ? bypass_word_reg : mem_rd_word;

        // The pixel one row up waits for its right neighbor unless it is on the border.
        inc_pend         = pend_valid_reg && (pend_forced_reg || !cur_word.up);
        upper_active     = (row_index_reg != '0) && cur_word.up;
        upper_border     = (row_index_reg == RowW'(1)) || (col_index_reg == '0) || last_col;
        inc_upper        = upper_active && upper_border;
        set_pend         = upper_active && !upper_border;
        pend_forced_next = !cur_word.above || !left_up_reg || !pix;
        inc_last         = last_row && pix;

        count_sum = running_count_reg + bcpc_pkg::CountW'(inc_pend)
                  + bcpc_pkg::CountW'(inc_upper) + bcpc_pkg::CountW'(inc_last);

        wr_word.above = cur_word.up;
        wr_word.up    = pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_index_reg     <= '0;
            col_index_reg     <= '0;
            running_count_reg <= '0;
            pend_valid_reg    <= 1'b0;
            rd_bypass_reg     <= 1'b0;
        end
        else if (in_accept)
        begin
            row_index_reg     <= row_index_next;
            col_index_reg     <= col_index_next;
            running_count_reg <= frame_done ? '0 : count_sum;
            pend_valid_reg    <= set_pend;
            rd_bypass_reg     <= (col_index_next == col_index_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pend_forced_reg <= pend_forced_next;
            left_up_reg     <= cur_word.up;
            bypass_word_reg <= wr_word;
        end
    end

    bcpc_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (ColW)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (in_accept),
        .wr_addr (col_index_reg),
        .wr_word (wr_word),
        .rd_en   (in_accept),
        .rd_addr (col_index_next),
        .rd_word (mem_rd_word)
    );

    bcpc_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept && frame_done),
        .push_count (count_sum),
        .in_ready   (buf_in_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_count  (out_count)
    );

    assign m_tdata = {{(bcpc_pkg::OutTdataW - bcpc_pkg::CountW){1'b0}}, out_count};

    `BCPC_ASSERT_IMP(a_stall_needs_result, clk, rst_n, !s_tready, m_tvalid, "stall without result")
    `BCPC_ASSERT_NEXT(a_frame_end_result, clk, rst_n, in_accept && frame_done, m_tvalid,
        "no result after frame end")
    `BCPC_ASSERT_NEXT(a_frame_end_restart, clk, rst_n, in_accept && frame_done,
        (row_index_reg == '0) && (col_index_reg == '0), "position not cleared at frame end")
    `BCPC_ASSERT_IMP(a_pend_not_col0, clk, rst_n, pend_valid_reg, col_index_reg != '0,
        "pending decision at first column")

endmodule

[bench/tb_binary_image_coast_pixel_counter.sv]
// Self-checking bench for the coast pixel counter: raster pixels in, one coast total per frame out.
// Depends on bcpc_pkg and the binary_image_coast_pixel_counter top level; an in-bench
// predictor computes each frame total and a monitor compares it with every output request.
module tb_binary_image_coast_pixel_counter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QuietLimit = 5000;
    localparam logic [bcpc_pkg::CfgIdxW-1:0] RegUnused = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bcpc_pkg::InTdataW-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bcpc_pkg::OutTdataW-1:0] m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bcpc_pkg::CfgIdxW-1:0]   cfg_index;
    logic [bcpc_pkg::CfgW-1:0]      cfg_data;

    // Predictor state.
    logic [bcpc_pkg::CfgW-1:0]           rows_cfg;
    logic [bcpc_pkg::CfgW-1:0]           cols_cfg;
    bit [bcpc_pkg::MaxColsDefault-1:0]   up_row;
    bit [bcpc_pkg::MaxColsDefault-1:0]   above_row;
    int                                  row_pos;
    int                                  col_pos;
    logic [bcpc_pkg::CountW-1:0]         coast_run;
    logic [bcpc_pkg::CountW-1:0]         coast_totals_q[$];

    int errors;
    int pixels_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int quiet_cycles;

    binary_image_coast_pixel_counter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int clamp_dim(input logic [bcpc_pkg::CfgW-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic void predict_coast_pixel(input bit land);
        int rows;
        int cols;
        int c;
        bit last_row;
        bit last_col;
        bit hit;
        rows = clamp_dim(rows_cfg, bcpc_pkg::MaxRowsDefault);
        cols = clamp_dim(cols_cfg, bcpc_pkg::MaxColsDefault);
        c = col_pos;
        last_row = (row_pos + 1 >= rows);
        last_col = (c + 1 >= cols);
        if (row_pos > 0 && up_row[c])
        begin
            if (row_pos == 1 || c == 0 || c + 1 >= cols)
                hit = 1'b1;
            else
                hit = !above_row[c] || !above_row[c-1] || !up_row[c+1] || !land;
            if (hit)
                coast_run = coast_run + 1'b1;
        end
        if (last_row && land)
            coast_run = coast_run + 1'b1;
        above_row[c] = up_row[c];
        up_row[c] = land;
        if (!last_col)
        begin
            col_pos = c + 1;
            return;
        end
        col_pos = 0;
        if (!last_row)
        begin
            row_pos = row_pos + 1;
            return;
        end
        coast_totals_q.push_back(coast_run);
        row_pos = 0;
        coast_run = '0;
    endfunction

    task automatic send_pixel(input bit land);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bcpc_pkg::InTdataW-1){1'b0}}, land};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_coast_pixel(land);
        pixels_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (coast_totals_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bcpc_pkg::CfgIdxW-1:0] idx,
                             input logic [bcpc_pkg::CfgW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bcpc_pkg::REG_IMAGE_ROWS: rows_cfg = val;
            bcpc_pkg::REG_IMAGE_COLS: cols_cfg = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [bcpc_pkg::CfgW-1:0] rows,
                            input logic [bcpc_pkg::CfgW-1:0] cols);
        wait_idle();
        write_reg(bcpc_pkg::REG_IMAGE_ROWS, rows);
        write_reg(bcpc_pkg::REG_IMAGE_COLS, cols);
    endtask

    task automatic send_frame(input int land_pct);
        int n;
        n = clamp_dim(rows_cfg, bcpc_pkg::MaxRowsDefault)
          * clamp_dim(cols_cfg, bcpc_pkg::MaxColsDefault);
        repeat (n) send_pixel($urandom_range(99) < land_pct);
    endtask

    task automatic send_pattern(input logic [15:0] bits, input int n);
        for (int i = 0; i < n; i++)
            send_pixel(bits[i]);
    endtask

    // Reset sizes, single pixels, a solid block and a block whose center sees water below.
    task automatic test_directed();
        send_pattern(16'h0001, 1);
        send_pattern(16'h0000, 1);
        set_size(11'd3, 11'd3);
        send_pattern(16'h01FF, 9);
        send_pattern(16'h017F, 9);
        set_size(11'd0, 11'd0);
        send_pattern(16'h0001, 1);
        wait_idle();
    endtask

    // Single rows, single columns, two-row frames, and writes to an index that holds no
    // register.
    task automatic test_size_extremes();
        set_size(11'd1, 11'd32);
        send_frame(70);
        wait_idle();
        write_reg(RegUnused, 11'd5);
        send_frame(60);
        set_size(11'd32, 11'd1);
        send_frame(85);
        set_size(11'd2, 11'd16);
        write_reg(RegUnused, 11'd2047);
        send_frame(90);
        wait_idle();
    endtask

    task automatic test_random_frames(input int target);
        int start;
        logic [bcpc_pkg::CfgW-1:0] r;
        logic [bcpc_pkg::CfgW-1:0] c;
        start = pixels_sent;
        while (pixels_sent - start < target)
        begin
            if ($urandom_range(3) != 0)
            begin
                r = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
                c = ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, 10));
                wait_idle();
                if ($urandom_range(1))
                    write_reg(bcpc_pkg::REG_IMAGE_ROWS, r);
                write_reg(bcpc_pkg::REG_IMAGE_COLS, c);
            end
            send_frame($urandom_range(40, 100));
        end
        wait_idle();
    endtask

    // The receiver holds off while tiny frames keep arriving, so the result side fills up.
    task automatic test_backpressure();
        set_size(11'd1, 11'd2);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        repeat (40) send_pixel($urandom_range(1));
        wait_idle();
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_counts
        logic [bcpc_pkg::CountW-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (coast_totals_q.size() == 0)
            begin
                errors++;
                $display("%0t: expected no count, actual %0d", $time,
                         m_tdata[bcpc_pkg::CountW-1:0]);
            end
            else
            begin
                want = coast_totals_q.pop_front();
                if (m_tdata[bcpc_pkg::CountW-1:0] !== want)
                begin
                    errors++;
                    $display("%0t: expected count %0d, actual %0d",
                             $time, want, m_tdata[bcpc_pkg::CountW-1:0]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = bcpc_pkg::REG_IMAGE_ROWS;
        cfg_data = '0;
        rows_cfg = 11'd1;
        cols_cfg = 11'd1;
        up_row = '0;
        above_row = '0;
        row_pos = 0;
        col_pos = 0;
        coast_run = '0;
        errors = 0;
        pixels_sent = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_size_extremes();
        send_idle_pct = 31;
        recv_idle_pct = 87;
        test_random_frames(60);
        send_idle_pct = 87;
        recv_idle_pct = 31;
        test_random_frames(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(60);
        test_backpressure();

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0 && coast_totals_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[sim.f]
+incdir+src
src/bcpc_pkg.sv
src/bcpc_line_store.sv
src/bcpc_result_buf.sv
src/binary_image_coast_pixel_counter.sv
bench/tb_binary_image_coast_pixel_counter.sv
